/* rtl/lst_pkg.sv */
package lst_pkg;

  localparam int NodeCountDefault = 16;
  localparam int SlotBits = 8;
  localparam int CntCount = 9;
  localparam int DivBits = 45;  // len*8*1e6 < 2^45
  localparam logic [49:0] Max50 = {50{1'b1}};
  localparam logic [22:0] Scale = 23'd8000000;

  typedef enum logic [2:0] {
    MODE_LOAD    = 3'd0,
    MODE_XMIT    = 3'd1,
    MODE_CHECK   = 3'd2,
    MODE_SETDIR  = 3'd3,
    MODE_RESTORE = 3'd4,
    MODE_NODE    = 3'd5,
    MODE_READ    = 3'd6,
    MODE_NOP     = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    CNT_SENT        = 4'd0,
    CNT_DROPPED     = 4'd1,
    CNT_BYTES       = 4'd2,
    CNT_HELLO_MSGS  = 4'd3,
    CNT_HELLO_BYTES = 4'd4,
    CNT_FLOOD_MSGS  = 4'd5,
    CNT_FLOOD_BYTES = 4'd6,
    CNT_UPD_MSGS    = 4'd7,
    CNT_UPD_BYTES   = 4'd8
  } cnt_t;

  typedef enum logic [1:0] {
    KIND_HELLO = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_FLOOD = 2'd2,
    KIND_BAD = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_EVAL, ST_MUL, ST_DIV, ST_SUM1, ST_SUM2,
    ST_REV_READ, ST_REV_EVAL, ST_CNT, ST_OUT, ST_CLEAR
  } state_t;

endpackage

/* rtl/link_serialization_timing.sv */
// Channel | Direction | Handshake       | Payload
// in      | input     | in_valid/stall  | mode .. counter_index
// out     | output    | out_valid/stall | status, arrival_us, counter_value
//
// One word at a time. Each goes idle, read, evaluate; then a sent transmit
// does multiply, the 45-step restoring divider of the bit-time product by
// bandwidth, two sums, counter update; a dropped transmit or deliver check,
// counter update; load and restore, reverse read and evaluate; then output.
// A stalled result holds in out_* and adds its stall. Reset clears failed
// flags and counters, then a pass over the 256 slots clears the link flags
// with in_stall high; delay, bandwidth and busy hold until loaded.
module link_serialization_timing #(
  parameter int NODE_COUNT = lst_pkg::NodeCountDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [3:0]  from_node,
  input  logic [3:0]  to_node,
  input  logic [15:0] length_bytes,
  input  logic [1:0]  packet_kind,
  input  logic [47:0] now_us,
  input  logic [31:0] delay_us,
  input  logic [36:0] bandwidth,
  input  logic        up_flag,
  input  logic [3:0]  counter_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [49:0] arrival_us,
  output logic [47:0] counter_value
);
  import lst_pkg::*;

  state_t state, state_next;

  // link memory: one word per directed slot, flags are {present, up}
  logic [31:0] mem_delay [256];
  logic [36:0] mem_bw    [256];
  logic [49:0] mem_busy  [256];
  logic [1:0]  mem_flags [256];
  logic [31:0] rd_delay;
  logic [36:0] rd_bw;
  logic [49:0] rd_busy;
  logic [1:0]  rd_flags;
  logic [15:0]  failed;
  logic [47:0]  cnt [CntCount];
  logic [7:0]   clr_addr;

  // captured word
  logic [2:0]  r_mode;
  logic [3:0]  r_from, r_to, r_cidx;
  logic [15:0] r_len;
  logic [1:0]  r_kind;
  logic [47:0] r_now;
  logic [31:0] r_delay;
  logic [36:0] r_bw;
  logic        r_up;
  logic        drop;

  logic [7:0]  rd_addr, wr_addr;
  logic        wr_en, wr_delay_en, wr_flag_en;
  logic [1:0]  wr_flags;
  logic [49:0] wr_busy;
  logic [31:0] wr_delay;
  logic [36:0] wr_bw;

  // divider
  logic [DivBits-1:0] quo;
  logic [37:0]        rem;
  logic [5:0]         step;
  logic [49:0]        start, busy_new;
  logic [50:0]        sum;

  logic [7:0] fwd, rev;
  assign fwd = {r_from, r_to};
  assign rev = {r_to, r_from};

  function automatic logic node_ok(input logic [3:0] n, input int nc);
    node_ok = 32'(n) < nc;
  endfunction

  logic from_up, to_up, dir_up, load_ok;
  assign from_up = !node_ok(r_from, NODE_COUNT) || !failed[r_from];
  assign to_up   = !node_ok(r_to, NODE_COUNT) || !failed[r_to];
  assign dir_up  = rd_flags[1] && rd_flags[0];
  assign load_ok = node_ok(r_from, NODE_COUNT) && node_ok(r_to, NODE_COUNT);

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    rd_delay <= mem_delay[rd_addr];
    rd_bw    <= mem_bw[rd_addr];
    rd_busy  <= mem_busy[rd_addr];
    rd_flags <= mem_flags[rd_addr];
    if (wr_en) begin
      mem_busy[wr_addr] <= wr_busy;
      if (wr_delay_en) begin
        mem_delay[wr_addr] <= wr_delay;
        mem_bw[wr_addr]    <= wr_bw;
      end
    end
    if (wr_flag_en) mem_flags[wr_addr] <= wr_flags;
  end

  always_comb begin
    rd_addr = (state == ST_REV_READ) ? rev : fwd;
    wr_en = 1'b0;
    wr_delay_en = 1'b0;
    wr_flag_en = 1'b0;
    wr_flags = '0;
    wr_addr = fwd;
    wr_busy = '0;
    wr_delay = r_delay;
    wr_bw = (r_bw == '0) ? 37'd1 : r_bw;
    sum = 51'(start) + 51'(quo);
    busy_new = sum[50] ? Max50 : sum[49:0];
    state_next = state;
    case (state)
      ST_CLEAR: begin
        wr_addr = clr_addr;
        wr_flag_en = 1'b1;
        if (clr_addr == 8'hFF) state_next = ST_IDLE;
      end
      ST_IDLE: if (in_valid) state_next = ST_READ;
      ST_READ: state_next = ST_EVAL;
      ST_EVAL: begin
        case (r_mode)
          MODE_LOAD: begin
            if (load_ok) begin
              wr_en = 1'b1; wr_delay_en = 1'b1;
              wr_flag_en = 1'b1; wr_flags = 2'b11;
            end
            state_next = ST_REV_READ;
          end
          MODE_XMIT:
            state_next = (from_up && to_up && dir_up) ? ST_MUL : ST_CNT;
          MODE_CHECK: state_next = ST_CNT;
          MODE_SETDIR: begin
            wr_flag_en = rd_flags[1];
            wr_flags = {1'b1, r_up};
            state_next = ST_OUT;
          end
          MODE_RESTORE: begin
            wr_en = rd_flags[1];
            wr_flag_en = rd_flags[1];
            wr_flags = 2'b11;
            wr_busy = {2'b0, r_now};
            state_next = ST_REV_READ;
          end
          default: state_next = ST_OUT;
        endcase
      end
      ST_MUL: state_next = ST_DIV;
      ST_DIV: if (step == 6'(DivBits)) state_next = ST_SUM1;
      ST_SUM1: begin
        wr_en = 1'b1;
        wr_busy = busy_new;
        state_next = ST_SUM2;
      end
      ST_SUM2: state_next = ST_CNT;
      ST_REV_READ: state_next = ST_REV_EVAL;
      ST_REV_EVAL: begin
        wr_addr = rev;
        wr_flags = 2'b11;
        if (r_mode == MODE_LOAD) begin
          wr_en = load_ok;
          wr_delay_en = 1'b1;
          wr_flag_en = load_ok;
        end else begin
          wr_en = rd_flags[1];
          wr_flag_en = rd_flags[1];
          wr_busy = {2'b0, r_now};
        end
        state_next = ST_OUT;
      end
      ST_CNT: state_next = ST_OUT;
      ST_OUT: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  logic [51:0] arr_sum;
  assign arr_sum = 52'(start) + 52'(rd_delay);

  always_ff @(posedge clk) begin
    if (rst) begin
      failed <= '0;
      clr_addr <= '0;
      for (int i = 0; i < CntCount; i++) cnt[i] <= '0;
    end else begin
      case (state)
        ST_CLEAR: clr_addr <= clr_addr + 8'd1;
        ST_IDLE: if (in_valid) begin
          r_mode <= mode; r_from <= from_node; r_to <= to_node;
          r_len <= length_bytes; r_kind <= packet_kind; r_now <= now_us;
          r_delay <= delay_us; r_bw <= bandwidth; r_up <= up_flag;
          r_cidx <= counter_index;
          status <= 1'b0; arrival_us <= '0; counter_value <= '0;
        end
        ST_EVAL: begin
          case (r_mode)
            MODE_XMIT: drop <= !(from_up && to_up && dir_up);
            MODE_CHECK: drop <= !(to_up && dir_up);
            MODE_NODE: if (node_ok(r_from, NODE_COUNT)) failed[r_from] <= !r_up;
            MODE_READ: if (r_cidx <= CNT_UPD_BYTES) counter_value <= cnt[r_cidx];
            default: ;
          endcase
          start <= (50'(r_now) > rd_busy) ? 50'(r_now) : rd_busy;
        end
        ST_MUL: begin
          quo <= DivBits'(r_len) * DivBits'(Scale);
          rem <= '0;
          step <= '0;
        end
        ST_DIV: if (step != 6'(DivBits)) begin
          // one restoring step per cycle, bandwidth never zero once loaded
          if ({rem[36:0], quo[DivBits-1]} >= {1'b0, rd_bw}) begin
            rem <= {rem[36:0], quo[DivBits-1]} - {1'b0, rd_bw};
            quo <= {quo[DivBits-2:0], 1'b1};
          end else begin
            rem <= {rem[36:0], quo[DivBits-1]};
            quo <= {quo[DivBits-2:0], 1'b0};
          end
          step <= step + 6'd1;
        end
        ST_SUM1: start <= busy_new;
        ST_SUM2: arrival_us <= arr_sum[51:50] != 2'b0 ? Max50 : arr_sum[49:0];
        ST_CNT: begin
          if (drop) begin
            status <= 1'b1;
            cnt[CNT_DROPPED] <= cnt[CNT_DROPPED] + 48'd1;
          end else if (r_mode == MODE_XMIT) begin
            cnt[CNT_SENT] <= cnt[CNT_SENT] + 48'd1;
            cnt[CNT_BYTES] <= cnt[CNT_BYTES] + 48'(r_len);
            if (r_kind == KIND_HELLO) begin
              cnt[CNT_HELLO_MSGS] <= cnt[CNT_HELLO_MSGS] + 48'd1;
              cnt[CNT_HELLO_BYTES] <= cnt[CNT_HELLO_BYTES] + 48'(r_len);
            end
            if (r_kind == KIND_UPDATE || r_kind == KIND_FLOOD) begin
              cnt[CNT_FLOOD_MSGS] <= cnt[CNT_FLOOD_MSGS] + 48'd1;
              cnt[CNT_FLOOD_BYTES] <= cnt[CNT_FLOOD_BYTES] + 48'(r_len);
            end
            if (r_kind == KIND_UPDATE) begin
              cnt[CNT_UPD_MSGS] <= cnt[CNT_UPD_MSGS] + 48'd1;
              cnt[CNT_UPD_BYTES] <= cnt[CNT_UPD_BYTES] + 48'(r_len);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = (state == ST_OUT);

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import lst_pkg::*;

  typedef struct {
    mode_t       mode;
    logic [3:0]  src;
    logic [3:0]  dst;
    logic [15:0] len;
    kind_t       kind;
    logic [47:0] now;
    logic [31:0] delay;
    logic [36:0] bw;
    logic        up;
    logic [3:0]  cidx;
  } link_cmd_t;

  typedef struct {
    logic        dropped;
    logic [49:0] arrival;
    logic [47:0] count;
  } link_result_t;

  class link_timing_scoreboard;
    bit          present [256];
    bit          dir_up [256];
    logic [31:0] delay_tab [256];
    logic [36:0] bw_tab [256];
    logic [49:0] busy_tab [256];
    bit          failed [16];
    logic [47:0] traffic [9];
    link_result_t awaited[$];
    int          fails;

    function void reset_state();
      foreach (present[i]) begin
        present[i] = 0;
        dir_up[i] = 0;
      end
      foreach (failed[i]) failed[i] = 0;
      foreach (traffic[i]) traffic[i] = '0;
      fails = 0;
    endfunction

    function void add(cnt_t idx, logic [47:0] amount);
      traffic[idx] = traffic[idx] + amount;
    endfunction

    function logic [49:0] sat_sum(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s > {14'd0, Max50}) ? Max50 : s[49:0];
    endfunction

    function void note_word(link_cmd_t c);
      link_result_t r;
      logic [7:0]  fwd, rev;
      logic [63:0] tx, start;
      logic [36:0] bw;
      fwd = {c.src, c.dst};
      rev = {c.dst, c.src};
      r = '{1'b0, '0, '0};
      case (c.mode)
        MODE_LOAD: begin
          bw = (c.bw == 0) ? 37'd1 : c.bw;
          present[fwd] = 1; dir_up[fwd] = 1;
          delay_tab[fwd] = c.delay; bw_tab[fwd] = bw; busy_tab[fwd] = '0;
          present[rev] = 1; dir_up[rev] = 1;
          delay_tab[rev] = c.delay; bw_tab[rev] = bw; busy_tab[rev] = '0;
        end
        MODE_XMIT: begin
          if (failed[c.src] || failed[c.dst] || !present[fwd] || !dir_up[fwd]) begin
            add(CNT_DROPPED, 1);
            r.dropped = 1;
          end else begin
            tx = (64'(c.len) * 64'd8000000) / 64'(bw_tab[fwd]);
            start = (64'(c.now) > 64'(busy_tab[fwd])) ? 64'(c.now) : 64'(busy_tab[fwd]);
            busy_tab[fwd] = sat_sum(start, tx);
            r.arrival = sat_sum(64'(busy_tab[fwd]), 64'(delay_tab[fwd]));
            add(CNT_SENT, 1);
            add(CNT_BYTES, c.len);
            case (c.kind)
              KIND_HELLO: begin
                add(CNT_HELLO_MSGS, 1); add(CNT_HELLO_BYTES, c.len);
              end
              KIND_UPDATE: begin
                add(CNT_FLOOD_MSGS, 1); add(CNT_FLOOD_BYTES, c.len);
                add(CNT_UPD_MSGS, 1); add(CNT_UPD_BYTES, c.len);
              end
              KIND_FLOOD: begin
                add(CNT_FLOOD_MSGS, 1); add(CNT_FLOOD_BYTES, c.len);
              end
              default: ;
            endcase
          end
        end
        MODE_CHECK: begin
          if (failed[c.dst] || !present[fwd] || !dir_up[fwd]) begin
            add(CNT_DROPPED, 1);
            r.dropped = 1;
          end
        end
        MODE_SETDIR: if (present[fwd]) dir_up[fwd] = c.up;
        MODE_RESTORE: begin
          if (present[fwd]) begin
            dir_up[fwd] = 1; busy_tab[fwd] = {2'b00, c.now};
          end
          if (present[rev]) begin
            dir_up[rev] = 1; busy_tab[rev] = {2'b00, c.now};
          end
        end
        MODE_NODE: failed[c.src] = !c.up;
        MODE_READ: if (c.cidx <= CNT_UPD_BYTES) r.count = traffic[c.cidx];
        default: ;
      endcase
      awaited.insert(awaited.size(), r);
    endfunction

    function void check_word(logic st, logic [49:0] arr, logic [47:0] cnt);
      link_result_t e;
      if (awaited.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
        return;
      end
      e = awaited.pop_front();
      if (st !== e.dropped) begin
        $error("status: expected %0d, actual %0d", e.dropped, st);
        fails++;
      end
      if (arr !== e.arrival) begin
        $error("arrival_us: expected %0d, actual %0d", e.arrival, arr);
        fails++;
      end
      if (cnt !== e.count) begin
        $error("counter_value: expected %0d, actual %0d", e.count, cnt);
        fails++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  mode = '0;
  logic [3:0]  from_node = '0;
  logic [3:0]  to_node = '0;
  logic [15:0] length_bytes = '0;
  logic [1:0]  packet_kind = '0;
  logic [47:0] now_us = '0;
  logic [31:0] delay_us = '0;
  logic [36:0] bandwidth = '0;
  logic        up_flag = 0;
  logic [3:0]  counter_index = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        status;
  logic [49:0] arrival_us;
  logic [47:0] counter_value;

  link_timing_scoreboard sb = new();
  bit          steady = 0;
  bit          hold_req = 0;
  int          quiet_cycles = 0;
  logic [47:0] clock_now = '0;

  link_serialization_timing DUT (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_word(status, arrival_us, counter_value);
      if (hold_req && held < 400) begin
        held++;
        out_stall <= 1;
        if (held == 400) hold_req = 0;
      end else begin
        held = 0;
        out_stall <= !steady && ($urandom_range(0, 99) < 16);
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= 5000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_word(link_cmd_t c);
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_valid <= 0;
      @(posedge clk);
    end
    mode <= c.mode;
    from_node <= c.src;
    to_node <= c.dst;
    length_bytes <= c.len;
    packet_kind <= c.kind;
    now_us <= c.now;
    delay_us <= c.delay;
    bandwidth <= c.bw;
    up_flag <= c.up;
    counter_index <= c.cidx;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_word(c);
  endtask

  function automatic link_cmd_t blank(mode_t m, int s, int d);
    link_cmd_t c;
    c = '{m, 4'(s), 4'(d), '0, KIND_HELLO, '0, '0, '0, 1'b1, '0};
    return c;
  endfunction

  function automatic logic [3:0] pick_node();
    return ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 3)) : 4'($urandom);
  endfunction

  function automatic link_cmd_t random_cmd();
    link_cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    c = blank(MODE_NOP, pick_node(), pick_node());
    if (r < 8) c.mode = MODE_LOAD;
    else if (r < 50) c.mode = MODE_XMIT;
    else if (r < 58) c.mode = MODE_CHECK;
    else if (r < 66) c.mode = MODE_SETDIR;
    else if (r < 72) c.mode = MODE_RESTORE;
    else if (r < 78) c.mode = MODE_NODE;
    else if (r < 95) c.mode = MODE_READ;
    case ($urandom_range(0, 9))
      0: c.len = '0;
      1: c.len = 16'hFFFF;
      default: c.len = 16'($urandom);
    endcase
    c.kind = kind_t'($urandom_range(0, 3));
    clock_now = clock_now + $urandom_range(0, 5000);
    c.now = ($urandom_range(0, 19) == 0) ? {16'($urandom), 32'($urandom)} : clock_now;
    c.delay = ($urandom_range(0, 1)) ? 32'($urandom) : 32'($urandom_range(0, 10000));
    case ($urandom_range(0, 9))
      0: c.bw = '0;
      1, 2: c.bw = {5'($urandom), 32'($urandom)};
      default: c.bw = 37'($urandom_range(1000, 1000000000));
    endcase
    c.up = $urandom_range(0, 3) != 0;
    c.cidx = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8));
    return c;
  endfunction

  initial begin
    link_cmd_t c;
    sb.reset_state();
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed: extremes, every mode, loopback link, failed nodes, bad counter index
    c = blank(MODE_XMIT, 1, 2); send_word(c);
    c = blank(MODE_CHECK, 1, 2); send_word(c);
    c = blank(MODE_LOAD, 1, 2); c.bw = '0; c.delay = '1; send_word(c);
    c = blank(MODE_XMIT, 1, 2); c.len = 16'hFFFF; c.now = '1; send_word(c);
    c = blank(MODE_XMIT, 2, 1); c.len = 16'hFFFF; c.kind = KIND_UPDATE; send_word(c);
    c = blank(MODE_LOAD, 15, 0); c.bw = '1; send_word(c);
    c = blank(MODE_XMIT, 0, 15); c.len = 16'hFFFF; c.kind = KIND_FLOOD; send_word(c);
    c = blank(MODE_XMIT, 15, 0); c.kind = KIND_BAD; send_word(c);
    c = blank(MODE_LOAD, 5, 5); c.bw = 37'd1000000; c.delay = 32'd7; send_word(c);
    c = blank(MODE_XMIT, 5, 5); c.len = 16'd100; send_word(c);
    c = blank(MODE_SETDIR, 1, 2); c.up = 0; send_word(c);
    c = blank(MODE_XMIT, 1, 2); send_word(c);
    c = blank(MODE_CHECK, 2, 1); send_word(c);
    c = blank(MODE_SETDIR, 7, 8); c.up = 1; send_word(c);
    c = blank(MODE_RESTORE, 2, 1); c.now = 48'h800000000000; send_word(c);
    c = blank(MODE_XMIT, 1, 2); c.len = 16'd1; send_word(c);
    c = blank(MODE_NODE, 15, 0); c.up = 0; send_word(c);
    c = blank(MODE_XMIT, 0, 15); send_word(c);
    c = blank(MODE_CHECK, 0, 15); send_word(c);
    c = blank(MODE_NODE, 15, 0); c.up = 1; send_word(c);
    c = blank(MODE_NOP, 3, 3); send_word(c);
    for (int i = 0; i < 16; i++) begin
      c = blank(MODE_READ, 0, 0); c.cidx = 4'(i); send_word(c);
    end

    for (int n = 0; n < 2000; n++) begin
      steady = (n >= 600 && n < 900);
      if (n == 1000) hold_req = 1;
      if (n == 1400) begin
        in_valid <= 0;
        wait (sb.awaited.size() == 0);
        repeat (20) @(posedge clk);
      end
      send_word(random_cmd());
    end
    in_valid <= 0;

    wait (sb.awaited.size() == 0);
    repeat (100) @(posedge clk);
    if (sb.fails == 0 && sb.awaited.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
